### rtl/assert_macros.svh
// assertion macros used by the checker file gbba_chk.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion clocked on clk, disabled while rst_n is low
`define GBBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gbba check failed");

// same check with a message given at the point of use
`define GBBA_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`endif

### rtl/gbba_pkg.sv
// shared constants, types and helpers of the block allocator
// no dependencies
package gbba_pkg;

  localparam int GROUPS           = 8;
  localparam int BLOCKS_PER_GROUP = 1024;
  localparam int BYTES_PER_GROUP  = BLOCKS_PER_GROUP / 8;
  localparam int MAP_BYTES        = GROUPS * BYTES_PER_GROUP;

  localparam int BLK_W  = 13;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 4;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int NG_W   = $clog2(GROUPS + 1);
  localparam int CNT_W  = $clog2(BLOCKS_PER_GROUP + 1);
  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int BYTE_W = (BYTES_PER_GROUP > 1) ? $clog2(BYTES_PER_GROUP) : 1;
  localparam int SPAN_W = (($clog2(GROUPS * BLOCKS_PER_GROUP + 1) > BLK_W) ?
                           $clog2(GROUPS * BLOCKS_PER_GROUP + 1) : BLK_W) + 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  typedef struct packed {
    logic             op;
    logic             has_blocks;
    logic [BLK_W-1:0] hint_block;
    logic [BLK_W-1:0] free_block;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0]  block;
    logic [STAT_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic             inc;
    logic             dec;
    logic [GRP_W-1:0] idx;
  } cnt_upd_t;

  function automatic logic [2:0] low_clear_bit(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (!b[k]) n = 3'(k);
    end
    return n;
  endfunction

endpackage

### rtl/grouped_bitmap_block_allocator.sv
// block allocator over grouped usage bitmaps with per-group free counts
// an allocate does a group walk, then scans its bitmap one bitmap byte a cycle; the next
// word can be taken in the cycle after the result enters the output register, so the
// block works on one word at a time
// after reset a clearing pass zeroes all MAP_BYTES bitmap bytes before the first word is
// accepted; counts and the config register reset at once
module grouped_bitmap_block_allocator import gbba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic              has_blocks_i,
  input  logic [BLK_W-1:0]  hint_block_i,
  input  logic [BLK_W-1:0]  free_block_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BLK_W-1:0]  block_o,
  output logic [STAT_W-1:0] status_o
);

  logic [CFG_W-1:0]  cfg_q;
  logic [NG_W-1:0]   ng;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;
  req_t              req;
  res_t              res;
  logic              res_valid, res_ready;
  logic [GRP_W-1:0]  cnt_idx;
  logic [CNT_W-1:0]  cnt_rd;
  cnt_upd_t          cnt_upd;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  always_comb begin
    if (cfg_q == '0) ng = NG_W'(1);
    else if (32'(cfg_q) > 32'(GROUPS)) ng = NG_W'(GROUPS);
    else ng = NG_W'(cfg_q);
  end

  assign req = '{op: op_i, has_blocks: has_blocks_i,
                 hint_block: hint_block_i, free_block: free_block_i};

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign block_o     = out_q.block;
  assign status_o    = out_q.status;

  gbba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ng_i        (ng),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .cnt_idx_o   (cnt_idx),
    .cnt_i       (cnt_rd),
    .cnt_upd_o   (cnt_upd),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  gbba_cnt u_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (cnt_idx),
    .rd_cnt_o (cnt_rd),
    .upd_i    (cnt_upd)
  );

  gbba_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### rtl/gbba_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module gbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/gbba_cnt.sv
// per-group free block counters
// depends on gbba_pkg
module gbba_cnt import gbba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [GRP_W-1:0] rd_idx_i,
  output logic [CNT_W-1:0] rd_cnt_o,
  input  cnt_upd_t         upd_i
);

  logic [CNT_W-1:0] cnt_q [GROUPS];

  assign rd_cnt_o = cnt_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) cnt_q[g] <= CNT_W'(BLOCKS_PER_GROUP);
    end else if (upd_i.inc) begin
      cnt_q[upd_i.idx] <= cnt_q[upd_i.idx] + CNT_W'(1);
    end else if (upd_i.dec) begin
      cnt_q[upd_i.idx] <= cnt_q[upd_i.idx] - CNT_W'(1);
    end
  end

endmodule

### rtl/gbba_ctrl.sv
// sequencer: group search, bitmap scan, read-modify-write of bitmap bytes
// depends on gbba_pkg
module gbba_ctrl import gbba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NG_W-1:0]   ng_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  req_t              req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o,
  output logic [GRP_W-1:0]  cnt_idx_o,
  input  logic [CNT_W-1:0]  cnt_i,
  output cnt_upd_t          cnt_upd_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [7:0]        mem_rdata_i
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_LOC     = 4'd2;
  localparam logic [3:0] S_MIN     = 4'd3;
  localparam logic [3:0] S_MINCHK  = 4'd4;
  localparam logic [3:0] S_WALK    = 4'd5;
  localparam logic [3:0] S_FREE_RD = 4'd6;
  localparam logic [3:0] S_FREE_WR = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  req_t              req_q, req_d;
  res_t              res_q, res_d;
  logic [GRP_W-1:0]  i_q, i_d, g_q, g_d;
  logic [SPAN_W-1:0] rbase_q, rbase_d, base_q, base_d;
  logic [ADDR_W-1:0] rbbase_q, rbbase_d, bbase_q, bbase_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [NG_W-1:0]   k_q, k_d;
  logic [2:0]        bit_q, bit_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [BYTE_W-1:0] rd_i_q, rd_i_d, chk_i_q, chk_i_d;
  logic              chk_v_q, chk_v_d;

  logic [BLK_W-1:0]  target;
  logic [SPAN_W-1:0] off, blk_sum;
  logic [2:0]        n_bit;
  logic              i_last, g_last;

  assign target  = (req_q.op == OP_FREE) ? req_q.free_block : req_q.hint_block;
  assign off     = SPAN_W'(target) - base_q;
  assign n_bit   = low_clear_bit(mem_rdata_i);
  assign blk_sum = base_q + SPAN_W'({chk_i_q, n_bit});
  assign i_last  = (NG_W'(i_q) + NG_W'(1)) >= ng_i;
  assign g_last  = (NG_W'(g_q) + NG_W'(1)) >= ng_i;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign cnt_idx_o   = (state_q == S_MIN) ? i_q : g_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    req_d    = req_q;
    res_d    = res_q;
    i_d      = i_q;
    g_d      = g_q;
    rbase_d  = rbase_q;
    base_d   = base_q;
    rbbase_d = rbbase_q;
    bbase_d  = bbase_q;
    best_d   = best_q;
    k_d      = k_q;
    bit_d    = bit_q;
    addr_d   = addr_q;
    rd_i_d   = rd_i_q;
    chk_i_d  = chk_i_q;
    chk_v_d  = chk_v_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = 8'd0;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q;
    cnt_upd_o   = '0;
    cnt_upd_o.idx = g_q;

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(MAP_BYTES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          req_d    = req_i;
          i_d      = '0;
          rbase_d  = '0;
          rbbase_d = '0;
          k_d      = '0;
          if (req_i.op == OP_FREE || req_i.has_blocks) state_d = S_LOC;
          else state_d = S_MIN;
        end
      end
      S_LOC: begin
        if (SPAN_W'(target) < rbase_q + SPAN_W'(BLOCKS_PER_GROUP)) begin
          g_d     = i_q;
          base_d  = rbase_q;
          bbase_d = rbbase_q;
          state_d = (req_q.op == OP_FREE) ? S_FREE_RD : S_WALK;
        end else if (i_last) begin
          res_d   = '{block: '0, status: ST_RANGE};
          state_d = S_DONE;
        end else begin
          i_d      = i_q + GRP_W'(1);
          rbase_d  = rbase_q + SPAN_W'(BLOCKS_PER_GROUP);
          rbbase_d = rbbase_q + ADDR_W'(BYTES_PER_GROUP);
        end
      end
      S_MIN: begin
        if (i_q == '0 || cnt_i < best_q) begin
          best_d  = cnt_i;
          g_d     = i_q;
          base_d  = rbase_q;
          bbase_d = rbbase_q;
        end
        if (i_last) begin
          state_d = S_MINCHK;
        end else begin
          i_d      = i_q + GRP_W'(1);
          rbase_d  = rbase_q + SPAN_W'(BLOCKS_PER_GROUP);
          rbbase_d = rbbase_q + ADDR_W'(BYTES_PER_GROUP);
        end
      end
      S_MINCHK: begin
        if (cnt_i == '0) begin
          res_d   = '{block: '0, status: ST_FULL};
          state_d = S_DONE;
        end else begin
          rd_i_d  = '0;
          chk_v_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_WALK: begin
        if (cnt_i != '0) begin
          rd_i_d  = '0;
          chk_v_d = 1'b0;
          state_d = S_SCAN;
        end else if ((k_q + NG_W'(1)) >= ng_i) begin
          res_d   = '{block: '0, status: ST_FULL};
          state_d = S_DONE;
        end else begin
          k_d = k_q + NG_W'(1);
          if (g_last) begin
            g_d     = '0;
            base_d  = '0;
            bbase_d = '0;
          end else begin
            g_d     = g_q + GRP_W'(1);
            base_d  = base_q + SPAN_W'(BLOCKS_PER_GROUP);
            bbase_d = bbase_q + ADDR_W'(BYTES_PER_GROUP);
          end
        end
      end
      S_FREE_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = bbase_q + ADDR_W'(off[SPAN_W-1:3]);
        addr_d      = mem_raddr_o;
        bit_d       = off[2:0];
        state_d     = S_FREE_WR;
      end
      S_FREE_WR: begin
        if (mem_rdata_i[bit_q]) begin
          mem_we_o      = 1'b1;
          mem_wdata_o   = mem_rdata_i & ~(8'd1 << bit_q);
          cnt_upd_o.inc = 1'b1;
        end
        res_d   = '{block: '0, status: ST_OK};
        state_d = S_DONE;
      end
      S_SCAN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = bbase_q + ADDR_W'(rd_i_q);
        addr_d      = mem_raddr_o;
        chk_i_d     = rd_i_q;
        chk_v_d     = 1'b1;
        if (rd_i_q != BYTE_W'(BYTES_PER_GROUP - 1)) rd_i_d = rd_i_q + BYTE_W'(1);
        if (chk_v_q && mem_rdata_i != BYTE_FULL) begin
          mem_we_o      = 1'b1;
          mem_wdata_o   = mem_rdata_i | (8'd1 << n_bit);
          cnt_upd_o.dec = 1'b1;
          res_d         = '{block: blk_sum[BLK_W-1:0], status: ST_OK};
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // scan writes go back to the byte that was checked
    if (state_q == S_SCAN) mem_waddr_o = addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      chk_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      chk_v_q <= chk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    res_q    <= res_d;
    i_q      <= i_d;
    g_q      <= g_d;
    rbase_q  <= rbase_d;
    base_q   <= base_d;
    rbbase_q <= rbbase_d;
    bbase_q  <= bbase_d;
    best_q   <= best_d;
    k_q      <= k_d;
    bit_q    <= bit_d;
    addr_q   <= addr_d;
    rd_i_q   <= rd_i_d;
    chk_i_q  <= chk_i_d;
  end

endmodule

### rtl/gbba_chk.sv
// port-level checks of the block allocator, bound to the top level
// depends on gbba_pkg and assert_macros.svh
`include "assert_macros.svh"

module gbba_chk import gbba_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [BLK_W-1:0]  block_o,
  input logic [STAT_W-1:0] status_o
);

  `GBBA_ASSERT(a_status_legal, clk_i, rst_ni,
    out_valid_o |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_RANGE))
  `GBBA_ASSERT(a_error_zero_block, clk_i, rst_ni,
    (out_valid_o && status_o != ST_OK) |-> (block_o == '0))
  `GBBA_ASSERT(a_one_word_at_a_time, clk_i, rst_ni,
    (in_valid_i && in_ready_o) |=> !in_ready_o)
  `GBBA_ASSERT_MSG(a_out_hold, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(block_o) && $stable(status_o)),
    "result word changed while held")

endmodule

bind grouped_bitmap_block_allocator gbba_chk u_gbba_chk (.*);

### bench/tb_grouped_bitmap_block_allocator.sv
// self-checking bench for grouped_bitmap_block_allocator: directed and random alloc/free
// words, with a bitmap and free-count model predicting every result word
// depends on gbba_pkg and grouped_bitmap_block_allocator from rtl
`timescale 1ns / 1ps

module tb_grouped_bitmap_block_allocator;
  import gbba_pkg::*;

  localparam logic [31:0] NO_BEST = 32'hFFFF_FFFF;
  localparam int IDLE_PCT = 37;
  localparam int HOLD_AT = 30000;
  localparam int HOLD_LEN = 600;
  localparam int CALM_FROM = 40000;
  localparam int CALM_TO = 70000;
  localparam int SETTLE = 160;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              op_i = 1'b0;
  logic              has_blocks_i = 1'b0;
  logic [BLK_W-1:0]  hint_block_i = '0;
  logic [BLK_W-1:0]  free_block_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [BLK_W-1:0]  block_o;
  logic [STAT_W-1:0] status_o;

  req_t        pending_requests[$];
  res_t        expected_results[$];
  logic [7:0]  map_model [MAP_BYTES];
  int unsigned free_model [GROUPS];
  logic [CFG_W-1:0] groups_model;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        calm;

  grouped_bitmap_block_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .has_blocks_i (has_blocks_i),
    .hint_block_i (hint_block_i),
    .free_block_i (free_block_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .block_o      (block_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  function automatic int unsigned clamp_groups(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GROUPS) return GROUPS;
    return 32'(v);
  endfunction

  function automatic res_t allocator_next(req_t rq);
    res_t        r;
    int unsigned ng, g, best, off, idx;
    logic        found, done;
    r.block = '0;
    r.status = ST_OK;
    found = 1'b0;
    done = 1'b0;
    g = 0;
    ng = clamp_groups(groups_model);
    if (rq.op == OP_FREE) begin
      g = rq.free_block / BLOCKS_PER_GROUP;
      if (g >= ng) begin
        r.status = ST_RANGE;
      end else begin
        off = rq.free_block % BLOCKS_PER_GROUP;
        idx = g * BYTES_PER_GROUP + off / 8;
        if (map_model[idx][off % 8]) begin
          map_model[idx][off % 8] = 1'b0;
          free_model[g]++;
        end
      end
    end else begin
      if (!rq.has_blocks) begin
        best = NO_BEST;
        for (int i = 0; i < ng; i++) begin
          if (free_model[i] < best) begin
            best = free_model[i];
            g = i;
          end
        end
        found = (free_model[g] != 0);
      end else begin
        g = rq.hint_block / BLOCKS_PER_GROUP;
        if (g >= ng) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = 0; i < ng && !found; i++) begin
            if (free_model[g] != 0) found = 1'b1;
            else g = (g + 1) % ng;
          end
        end
      end
      if (found) begin
        for (int b = 0; b < BYTES_PER_GROUP && !done; b++) begin
          idx = g * BYTES_PER_GROUP + b;
          if (map_model[idx] != BYTE_FULL) begin
            for (int k = 0; k < 8 && !done; k++) begin
              if (!map_model[idx][k]) begin
                map_model[idx][k] = 1'b1;
                r.block = BLK_W'(g * BLOCKS_PER_GROUP + b * 8 + k);
                done = 1'b1;
              end
            end
          end
        end
        free_model[g]--;
      end else if (r.status == ST_OK) begin
        r.status = ST_FULL;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_request(logic op, logic hb, int hint, int fb);
    req_t it;
    it.op = op;
    it.has_blocks = hb;
    it.hint_block = BLK_W'(hint);
    it.free_block = BLK_W'(fb);
    pending_requests.push_back(it);
  endtask

  task automatic queue_random(int count, int unsigned ng, int alloc_pct);
    req_t        it;
    int unsigned g;
    for (int n = 0; n < count; n++) begin
      it.has_blocks = 1'($urandom_range(1));
      it.hint_block = BLK_W'($urandom);
      it.free_block = BLK_W'($urandom);
      g = $urandom_range(ng - 1);
      if ($urandom_range(99) < alloc_pct) begin
        it.op = OP_ALLOC;
        if ($urandom_range(9) != 0) it.hint_block = BLK_W'($urandom_range(ng * BLOCKS_PER_GROUP - 1));
      end else begin
        it.op = OP_FREE;
        if ($urandom_range(9) != 0) begin
          if ($urandom_range(1)) it.free_block = BLK_W'(g * BLOCKS_PER_GROUP + $urandom_range(63));
          else it.free_block = BLK_W'(g * BLOCKS_PER_GROUP + $urandom_range(BLOCKS_PER_GROUP - 1));
        end
      end
      pending_requests.push_back(it);
    end
  endtask

  task automatic write_groups(logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    groups_model = v;
  endtask

  task automatic drain_block(int settle);
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    req_t seen, nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= OP_ALLOC;
      has_blocks_i <= 1'b0;
      hint_block_i <= '0;
      free_block_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen.op = op_i;
        seen.has_blocks = has_blocks_i;
        seen.hint_block = hint_block_i;
        seen.free_block = free_block_i;
        expected_results.push_back(allocator_next(seen));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          op_i <= nxt.op;
          has_blocks_i <= nxt.has_blocks;
          hint_block_i <= nxt.hint_block;
          free_block_i <= nxt.free_block;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == HOLD_AT) hold_left <= HOLD_LEN;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_ready_i <= (hold_left == 0) && (cycle_count != HOLD_AT) &&
                     (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_words
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected word block=%0d status=%0d", block_o, status_o));
      end else begin
        want = expected_results.pop_front();
        if (block_o !== want.block)
          flag_mismatch($sformatf("block %0d, want %0d", block_o, want.block));
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb_grouped_bitmap_block_allocator: errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAP_BYTES; i++) map_model[i] = 8'h00;
    for (int g = 0; g < GROUPS; g++) free_model[g] = BLOCKS_PER_GROUP;
    groups_model = CFG_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_groups(4'd8);
    add_request(OP_ALLOC, 1'b0, 0, 0);
    add_request(OP_ALLOC, 1'b0, 0, 0);
    add_request(OP_ALLOC, 1'b1, 0, 0);
    add_request(OP_ALLOC, 1'b1, 8191, 0);
    add_request(OP_ALLOC, 1'b1, 3 * 1024 + 517, 0);
    add_request(OP_ALLOC, 1'b1, 1024, 8191);
    add_request(OP_FREE, 1'b0, 0, 0);
    add_request(OP_FREE, 1'b0, 0, 0);
    add_request(OP_FREE, 1'b0, 0, 8191);
    add_request(OP_FREE, 1'b1, 8191, 7168);
    add_request(OP_ALLOC, 1'b0, 8191, 8191);
    drain_block(SETTLE);

    // zero acts as one group
    write_groups(4'd0);
    add_request(OP_ALLOC, 1'b1, 1024, 0);
    add_request(OP_FREE, 1'b0, 0, 1024);
    add_request(OP_FREE, 1'b0, 0, 8191);
    add_request(OP_ALLOC, 1'b1, 1023, 0);
    add_request(OP_ALLOC, 1'b0, 0, 0);
    add_request(OP_FREE, 1'b1, 4000, 1023);
    drain_block(SETTLE);

    // above the group count acts as all groups
    write_groups(4'd15);
    add_request(OP_ALLOC, 1'b1, 8191, 0);
    add_request(OP_FREE, 1'b0, 0, 4095);
    add_request(OP_ALLOC, 1'b0, 0, 0);
    add_request(OP_ALLOC, 1'b1, 5000, 0);
    drain_block(SETTLE);

    // one group, filled past capacity
    write_groups(4'd1);
    queue_random(1100, 1, 97);
    drain_block(SETTLE);

    // group 0 full, group 1 open: fewest-free picks the full one
    write_groups(4'd2);
    queue_random(300, 2, 65);
    drain_block(SETTLE);

    write_groups(4'd8);
    queue_random(400, 8, 60);
    drain_block(SETTLE);

    write_groups(4'd5);
    queue_random(200, 5, 55);
    drain_block(SETTLE);

    write_groups(4'd9);
    queue_random(100, 8, 50);
    drain_block(SETTLE);

    if (error_count == 0) begin
      $display("tb_grouped_bitmap_block_allocator: clean");
    end else begin
      $display("tb_grouped_bitmap_block_allocator: errors");
    end
    $finish;
  end

endmodule
